// File: hdl/bnv_pkg.sv
// shared constants and types of the rgb to nv12 converter
`default_nettype none

package bnv_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 16384;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = 13;
    localparam int FH_W       = 15;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int PSUM_W     = 9;
    localparam int LINE_W     = 3 * PSUM_W;
    localparam int BSUM_W     = PSUM_W + 1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(1920);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(1080);

    // register indexes on the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // result kinds
    localparam logic KIND_LUMA   = 1'b0;
    localparam logic KIND_CHROMA = 1'b1;

    // result slots of one request, in output order
    localparam int RES_OWN    = 0;
    localparam int RES_RIGHT  = 1;
    localparam int RES_BOTTOM = 2;
    localparam int RES_CORNER = 3;
    localparam int RES_CHROMA = 4;
    localparam int RES_N      = 5;

    typedef logic [RES_N-1:0] res_mask_t;

    // pixel as it leaves the front stage
    typedef struct packed {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [PSUM_W-1:0] pair_red;
        logic [PSUM_W-1:0] pair_green;
        logic [PSUM_W-1:0] pair_blue;
        logic              use_line;
        res_mask_t         mask;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              frame_end;
    } bnv_item_t;

    // finished values of one request, ready for the output sequencer
    typedef struct packed {
        res_mask_t        mask;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       luma;
        logic [7:0]       chroma_blue;
        logic [7:0]       chroma_red;
        logic             frame_end;
    } bnv_bundle_t;

endpackage

`default_nettype wire

// File: hdl/bnv_line_ram.sv
// line store of even-row pair sums, one write and one registered read port
`default_nettype none

module bnv_line_ram (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [bnv_pkg::LINE_AW-1:0] wr_addr,
    input  wire logic [bnv_pkg::LINE_W-1:0]  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [bnv_pkg::LINE_AW-1:0] rd_addr,
    output logic      [bnv_pkg::LINE_W-1:0]  rd_data
);
    import bnv_pkg::*;

    logic [LINE_W-1:0] mem [LINE_DEPTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/bnv_front.sv
// front stage: position counters, held even pixel, pair sums and line store access
`default_nettype none

module bnv_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [bnv_pkg::FW_W-1:0]    frame_width,
    input  wire logic [bnv_pkg::FH_W-1:0]    frame_height,
    input  wire logic                        accept,
    input  wire logic [7:0]                  red,
    input  wire logic [7:0]                  green,
    input  wire logic [7:0]                  blue,
    output bnv_pkg::bnv_item_t               item,
    output logic      [bnv_pkg::LINE_W-1:0]  line_data
);
    import bnv_pkg::*;

    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [23:0]      held_reg, held_next;

    logic [FW_W-1:0]   width_eff;
    logic [FH_W-1:0]   height_eff;
    logic              last_col, last_row, pad_right, pad_bottom;
    logic              chroma_col, chroma_out;
    logic [PSUM_W-1:0] pr, pg, pb;
    logic              wr_en, rd_en;

    // register values out of range act as the nearest legal size
    always_comb
    begin
        priority if (frame_width == '0)
            width_eff = FW_W'(1);
        else if (frame_width > FW_W'(MAX_WIDTH))
            width_eff = FW_W'(MAX_WIDTH);
        else
            width_eff = frame_width;

        priority if (frame_height == '0)
            height_eff = FH_W'(1);
        else if (frame_height > FH_W'(MAX_HEIGHT))
            height_eff = FH_W'(MAX_HEIGHT);
        else
            height_eff = frame_height;
    end

    assign last_col   = (FW_W'(col_count_reg) + FW_W'(1)) >= width_eff;
    assign last_row   = (FH_W'(row_count_reg) + FH_W'(1)) >= height_eff;
    assign pad_right  = last_col && !col_count_reg[0];
    assign pad_bottom = last_row && !row_count_reg[0];
    assign chroma_col = col_count_reg[0] || pad_right;
    assign chroma_out = chroma_col && (row_count_reg[0] || pad_bottom);

    // horizontal pair sums: odd column pairs with the held pixel, padding doubles
    always_comb
    begin
        if (col_count_reg[0])
        begin
            pr = {1'b0, held_reg[7:0]}   + {1'b0, red};
            pg = {1'b0, held_reg[15:8]}  + {1'b0, green};
            pb = {1'b0, held_reg[23:16]} + {1'b0, blue};
        end
        else
        begin
            pr = {red, 1'b0};
            pg = {green, 1'b0};
            pb = {blue, 1'b0};
        end
    end

    assign wr_en = accept && chroma_col && !row_count_reg[0] && !pad_bottom;
    assign rd_en = accept && chroma_col && row_count_reg[0];

    bnv_line_ram u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (col_count_reg[COL_W-1:1]),
        .wr_data ({pb, pg, pr}),
        .rd_en   (rd_en),
        .rd_addr (col_count_reg[COL_W-1:1]),
        .rd_data (line_data)
    );

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        held_next      = held_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
            if (!chroma_col)
            begin
                held_next = {blue, green, red};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            held_reg      <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            held_reg      <= held_next;
        end
    end

    always_comb
    begin
        item                  = '0;
        item.red              = red;
        item.green            = green;
        item.blue             = blue;
        item.pair_red         = pr;
        item.pair_green       = pg;
        item.pair_blue        = pb;
        item.use_line         = row_count_reg[0];
        item.mask[RES_OWN]    = 1'b1;
        item.mask[RES_RIGHT]  = pad_right;
        item.mask[RES_BOTTOM] = pad_bottom;
        item.mask[RES_CORNER] = pad_right && pad_bottom;
        item.mask[RES_CHROMA] = chroma_out;
        item.row              = row_count_reg;
        item.col              = col_count_reg;
        item.frame_end        = last_col && last_row;
    end

endmodule

`default_nettype wire

// File: hdl/bnv_color.sv
// colour maths: block sums and products, then luma and chroma results
`default_nettype none

module bnv_color (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire bnv_pkg::bnv_item_t         item,
    input  wire logic [bnv_pkg::LINE_W-1:0] line_data,
    output logic                            in_ready,
    input  wire logic                       bund_ready,
    output logic                            bund_valid,
    output bnv_pkg::bnv_bundle_t            bundle
);
    import bnv_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    bnv_item_t s1_reg;
    logic      s2_valid_reg, s2_valid_next;
    logic      s1_ready, s2_ready;

    logic [BSUM_W-1:0] sr, sg, sb;
    logic [15:0]       y_sum;
    logic [7:0]        luma_next;
    logic [16:0]       cb_r_next, cb_g_next, cb_b_next;
    logic [16:0]       cr_r_next, cr_g_next, cr_b_next;

    logic [7:0]       luma_reg;
    logic [16:0]      cb_r_reg, cb_g_reg, cb_b_reg;
    logic [16:0]      cr_r_reg, cr_g_reg, cr_b_reg;
    res_mask_t        mask_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             frame_end_reg;

    logic [17:0] cb_v, cr_v;

    assign s2_ready = !s2_valid_reg || bund_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // block sums: odd row adds the stored even-row pair, padded row doubles
    always_comb
    begin
        if (s1_reg.use_line)
        begin
            sr = {1'b0, s1_reg.pair_red}   + {1'b0, line_data[PSUM_W-1:0]};
            sg = {1'b0, s1_reg.pair_green} + {1'b0, line_data[2*PSUM_W-1:PSUM_W]};
            sb = {1'b0, s1_reg.pair_blue}  + {1'b0, line_data[3*PSUM_W-1:2*PSUM_W]};
        end
        else
        begin
            sr = {s1_reg.pair_red, 1'b0};
            sg = {s1_reg.pair_green, 1'b0};
            sb = {s1_reg.pair_blue, 1'b0};
        end
    end

    // luma peaks at 235, so no clamp is needed
    assign y_sum = {8'd0, s1_reg.red} * 16'd47 + {8'd0, s1_reg.green} * 16'd157
                 + {8'd0, s1_reg.blue} * 16'd16 + 16'd128;
    assign luma_next = y_sum[15:8] + 8'd16;

    assign cb_r_next = {7'd0, sr} * 17'd26;
    assign cb_g_next = {7'd0, sg} * 17'd87;
    assign cb_b_next = {7'd0, sb} * 17'd112;
    assign cr_r_next = {7'd0, sr} * 17'd112;
    assign cr_g_next = {7'd0, sg} * 17'd102;
    assign cr_b_next = {7'd0, sb} * 17'd10;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = accept;
        end
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= item;
        end
        if (s2_ready && s1_valid_reg)
        begin
            luma_reg      <= luma_next;
            cb_r_reg      <= cb_r_next;
            cb_g_reg      <= cb_g_next;
            cb_b_reg      <= cb_b_next;
            cr_r_reg      <= cr_r_next;
            cr_g_reg      <= cr_g_next;
            cr_b_reg      <= cr_b_next;
            mask_reg      <= s1_reg.mask;
            row_reg       <= s1_reg.row;
            col_reg       <= s1_reg.col;
            frame_end_reg <= s1_reg.frame_end;
        end
    end

    // 128*1024 + 512 bias keeps both sums positive for any 8-bit input,
    // and the top byte then never exceeds 240
    assign cb_v = 18'(cb_b_reg) + 18'd131584 - 18'(cb_r_reg) - 18'(cb_g_reg);
    assign cr_v = 18'(cr_r_reg) + 18'd131584 - 18'(cr_g_reg) - 18'(cr_b_reg);

    assign bund_valid = s2_valid_reg;

    always_comb
    begin
        bundle             = '0;
        bundle.mask        = mask_reg;
        bundle.row         = row_reg;
        bundle.col         = col_reg;
        bundle.luma        = luma_reg;
        bundle.chroma_blue = cb_v[17:10];
        bundle.chroma_red  = cr_v[17:10];
        bundle.frame_end   = frame_end_reg;
    end

endmodule

`default_nettype wire

// File: hdl/bnv_emit.sv
// result sequencer: walks the result slots of each request into the output register
`default_nettype none

module bnv_emit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         bund_valid,
    input  wire bnv_pkg::bnv_bundle_t         bundle,
    output logic                              bund_ready,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              kind,
    output logic      [bnv_pkg::ROW_W-1:0]    out_row,
    output logic      [bnv_pkg::COL_W-1:0]    out_column,
    output logic      [7:0]                   luma,
    output logic      [7:0]                   chroma_blue,
    output logic      [7:0]                   chroma_red,
    output logic                              last_of_item,
    output logic                              frame_done
);
    import bnv_pkg::*;

    logic        hold_valid_reg, hold_valid_next;
    bnv_bundle_t hold_reg;
    res_mask_t   mask_reg, mask_next;
    res_mask_t   sel, rest;
    logic        out_free, emit, last_slot;

    logic             out_valid_reg, out_valid_next;
    logic             kind_reg, kind_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [7:0]       luma_reg, luma_next;
    logic [7:0]       cb_reg, cb_next;
    logic [7:0]       cr_reg, cr_next;
    logic             last_reg, last_next;
    logic             done_reg, done_next;

    assign out_free   = !out_valid_reg || out_ready;
    assign emit       = hold_valid_reg && out_free;
    assign sel        = mask_reg & (~mask_reg + res_mask_t'(1));
    assign rest       = mask_reg & ~sel;
    assign last_slot  = (rest == '0);
    assign bund_ready = !hold_valid_reg || (emit && last_slot);

    always_comb
    begin
        row_next  = hold_reg.row;
        col_next  = hold_reg.col;
        kind_next = KIND_LUMA;
        luma_next = hold_reg.luma;
        cb_next   = '0;
        cr_next   = '0;
        priority if (sel[RES_OWN])
        begin
            row_next = hold_reg.row;
        end
        else if (sel[RES_RIGHT])
        begin
            col_next = hold_reg.col + COL_W'(1);
        end
        else if (sel[RES_BOTTOM])
        begin
            row_next = hold_reg.row + ROW_W'(1);
        end
        else if (sel[RES_CORNER])
        begin
            row_next = hold_reg.row + ROW_W'(1);
            col_next = hold_reg.col + COL_W'(1);
        end
        else
        begin
            kind_next = KIND_CHROMA;
            row_next  = {1'b0, hold_reg.row[ROW_W-1:1]};
            col_next  = {hold_reg.col[COL_W-1:1], 1'b0};
            luma_next = '0;
            cb_next   = hold_reg.chroma_blue;
            cr_next   = hold_reg.chroma_red;
        end
        last_next = last_slot;
        done_next = last_slot && hold_reg.frame_end;
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        mask_next       = mask_reg;
        out_valid_next  = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            mask_next      = rest;
        end
        if (bund_ready)
        begin
            hold_valid_next = bund_valid;
            mask_next       = bundle.mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            mask_reg       <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            mask_reg       <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bund_ready && bund_valid)
        begin
            hold_reg <= bundle;
        end
        if (emit)
        begin
            kind_reg <= kind_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            luma_reg <= luma_next;
            cb_reg   <= cb_next;
            cr_reg   <= cr_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_row      = row_reg;
    assign out_column   = col_reg;
    assign luma         = luma_reg;
    assign chroma_blue  = cb_reg;
    assign chroma_red   = cr_reg;
    assign last_of_item = last_reg;
    assign frame_done   = done_reg;

endmodule

`default_nettype wire

// File: hdl/bgra_to_nv12_bt709.sv
// path: an accepted request passes the stage 1, product, hold and output result registers
// throughput: one request per cycle while each gives one result and out_ready is high;
// a request with n results holds the single output port until all n are sent
// the output sequencer and its one result register set the rate
// reset: position counters and held pixel clear, registers go to 1920 x 1080,
// line store is not cleared and needs no clearing pass
`default_nettype none

module bgra_to_nv12_bt709 (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    // pixel input
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                red,
    input  wire logic [7:0]                green,
    input  wire logic [7:0]                blue,
    // results
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           kind,
    output logic      [bnv_pkg::ROW_W-1:0] out_row,
    output logic      [bnv_pkg::COL_W-1:0] out_column,
    output logic      [7:0]                luma,
    output logic      [7:0]                chroma_blue,
    output logic      [7:0]                chroma_red,
    output logic                           last_of_item,
    output logic                           frame_done
);
    import bnv_pkg::*;

    logic [FW_W-1:0] frame_width_reg, frame_width_next;
    logic [FH_W-1:0] frame_height_reg, frame_height_next;
    logic            cfg_write;
    logic            accept;

    bnv_item_t       item;
    logic [LINE_W-1:0] line_data;
    logic            bund_valid, bund_ready;
    bnv_bundle_t     bundle;

    // register file: word address picks the register, pready never stalls
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_next  = pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = pwdata[FH_W-1:0];
                default:          frame_width_next  = frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = {{(32-FW_W){1'b0}}, frame_width_reg};
            REG_FRAME_HEIGHT: prdata = {{(32-FH_W){1'b0}}, frame_height_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    assign accept = in_valid && in_ready;

    // front: counters, held pixel, pair sums; even rows write the line store,
    // odd rows read it, so a read always follows the matching write by one row
    bnv_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .accept       (accept),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .item         (item),
        .line_data    (line_data)
    );

    // two stages of arithmetic with stall, products registered between them
    bnv_color u_color (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .line_data  (line_data),
        .in_ready   (in_ready),
        .bund_ready (bund_ready),
        .bund_valid (bund_valid),
        .bundle     (bundle)
    );

    // one result per cycle while out_ready is high, in order: own luma, padding lumas, chroma pair
    bnv_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .bund_valid   (bund_valid),
        .bundle       (bundle),
        .bund_ready   (bund_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_row      (out_row),
        .out_column   (out_column),
        .luma         (luma),
        .chroma_blue  (chroma_blue),
        .chroma_red   (chroma_red),
        .last_of_item (last_of_item),
        .frame_done   (frame_done)
    );

endmodule

`default_nettype wire
